// File: design/galactic_equatorial_rotation_core_assert.svh
// Assertion macros for the equatorial/galactic rotation core.
`ifndef GALACTIC_EQUATORIAL_ROTATION_CORE_ASSERT_SVH
`define GALACTIC_EQUATORIAL_ROTATION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define GER_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define GER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GER_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define GER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/ger_pkg.sv
// Shared widths, elaboration-time constant builders and rotation constants.
package ger_pkg;

    localparam int ANGLE_BITS_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 28;
    localparam int PW       = 48;           // internal phase width, 2^48 per turn
    localparam int FRAC_BITS = 30;          // Q30 for sines and cosines
    localparam int QW       = 36;           // signed Q30 datapath width
    localparam int PROD_W   = 2 * QW;
    localparam int RAD_W    = 2 * FRAC_BITS + 1;
    localparam int ROOT_W   = FRAC_BITS + 1;

    // Restoring divide of (n << s) by d, 64-bit quotient.
    function automatic logic [63:0] f_div_shift(input logic [63:0] n, input int s,
                                                input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        logic        bt;
        q   = '0;
        rem = '0;
        for (int b = 63 + s; b >= 0; b--) begin
            bt = 1'b0;
            if (b >= s) bt = n[b - s];
            rem = {rem[62:0], bt};
            q   = {q[62:0], 1'b0};
            if (rem >= d) begin
                rem  = rem - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) scaled by 2^60, Taylor series.
    function automatic logic [63:0] f_arctan_inv(input logic [63:0] n);
        logic [63:0] t;
        logic [63:0] sum;
        logic [63:0] k;
        logic [63:0] nn;
        logic        done;
        t    = f_div_shift(64'd1 << 60, 0, n);
        sum  = t;
        k    = 64'd1;
        nn   = n * n;
        done = 1'b0;
        for (int it = 0; it < 64; it++) begin
            if (!done) begin
                t = f_div_shift(t, 0, nn);
                if (t == '0) begin
                    done = 1'b1;
                end else begin
                    if (k[0]) sum = sum - f_div_shift(t, 0, 2 * k + 1);
                    else      sum = sum + f_div_shift(t, 0, 2 * k + 1);
                    k = k + 1;
                end
            end
        end
        return sum;
    endfunction

    // atan(2^-i) scaled by 2^60, i >= 1.
    function automatic logic [63:0] f_arctan_pow2(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        for (int k = 0; k <= 60; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = f_div_shift(64'd1 << (60 - e), 0, 64'(2 * k + 1));
                if (k % 2 == 1) sum = sum - term;
                else            sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic logic [63:0] f_pi60();
        return 64'd4 * (64'd4 * f_arctan_inv(64'd5) - f_arctan_inv(64'd239));
    endfunction

    function automatic logic [PW-1:0] f_rad_to_phase(input logic [63:0] r60);
        logic [63:0] q;
        q = f_div_shift(r60, PW - 2, f_pi60() >> 1);
        return q[PW-1:0];
    endfunction

    // CORDIC arctangent table entry in phase units.
    function automatic logic [PW-1:0] f_arc(input int i);
        if (i == 0) return f_rad_to_phase(f_pi60() >> 2);
        return f_rad_to_phase(f_arctan_pow2(i));
    endfunction

    localparam logic [PW-1:0] NODE_SMALL =
        f_rad_to_phase(f_div_shift(64'd57477043300, 60, 64'd100000000000));
    localparam logic [PW-1:0] NODE_LARGE =
        f_rad_to_phase(f_div_shift(64'd49368292465, 60, 64'd10000000000));
    localparam logic [63:0] TILT_S64 =
        f_div_shift(64'd88998808748, FRAC_BITS, 64'd100000000000);
    localparam logic [63:0] TILT_C64 =
        f_div_shift(64'd45598377618, FRAC_BITS, 64'd100000000000);
    localparam logic [63:0] GAIN64 =
        f_div_shift(64'd607252935008881256, FRAC_BITS, 64'd1000000000000000000);
    localparam logic signed [QW-1:0] TILT_S = TILT_S64[QW-1:0];
    localparam logic signed [QW-1:0] TILT_C = TILT_C64[QW-1:0];
    localparam logic signed [QW-1:0] CORDIC_GAIN = GAIN64[QW-1:0];

    localparam logic ACT_EQ_TO_GAL = 1'b0;
    localparam logic ACT_GAL_TO_EQ = 1'b1;

endpackage

// File: design/ger_sincos.sv
// Rotation-mode CORDIC pipeline: cosine and sine of a 48-bit phase.
module ger_sincos #(
    parameter int STAGES = ger_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [ger_pkg::PW-1:0]        i_phase,
    output logic                          o_valid,
    output logic signed [ger_pkg::QW-1:0] o_cos,
    output logic signed [ger_pkg::QW-1:0] o_sin
);
    import ger_pkg::*;

    logic                 r_v [0:STAGES];
    logic [1:0]           r_q [0:STAGES];
    logic signed [QW-1:0] r_x [0:STAGES];
    logic signed [QW-1:0] r_y [0:STAGES];
    logic signed [PW-1:0] r_z [0:STAGES];
    logic [PW-1:0]        w_rnd;
    logic [1:0]           w_q;

    // quadrant from phase rounded by an eighth turn
    assign w_rnd = i_phase + (PW'(1) << (PW - 3));
    assign w_q   = w_rnd[PW-1 -: 2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q[0] <= w_q;
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= i_phase - {w_q, {(PW - 2){1'b0}}};
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic [PW-1:0] ARC = f_arc(g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[g+1] <= r_q[g];
                if (!r_z[g][PW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ARC;
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ARC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[STAGES];
        end
    end

    // undo the quadrant reduction
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            case (r_q[STAGES])
                2'd0: begin
                    o_cos <= r_x[STAGES];
                    o_sin <= r_y[STAGES];
                end
                2'd1: begin
                    o_cos <= -r_y[STAGES];
                    o_sin <= r_x[STAGES];
                end
                2'd2: begin
                    o_cos <= -r_x[STAGES];
                    o_sin <= -r_y[STAGES];
                end
                default: begin
                    o_cos <= r_y[STAGES];
                    o_sin <= -r_x[STAGES];
                end
            endcase
        end
    end

endmodule

// File: design/ger_isqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
module ger_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [ger_pkg::RAD_W-1:0]    i_rad,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic [ger_pkg::ROOT_W-1:0]   o_root,
    output logic [SIDE_W-1:0]            o_side
);
    import ger_pkg::*;

    localparam int STEPS = FRAC_BITS + 1;
    localparam int RW    = RAD_W + 1;

    logic              r_v    [0:STEPS];
    logic [RAD_W-1:0]  r_rem  [0:STEPS];
    logic [RW-1:0]     r_root [0:STEPS];
    logic [SIDE_W-1:0] r_side [0:STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_rad;
            r_root[0] <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * FRAC_BITS - 2 * g);
        logic [RW-1:0] w_trial;

        assign w_trial = r_root[g] + BIT;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[g+1] <= r_side[g];
                if ({1'b0, r_rem[g]} >= w_trial) begin
                    r_rem[g+1]  <= RAD_W'({1'b0, r_rem[g]} - w_trial);
                    r_root[g+1] <= (r_root[g] >> 1) + BIT;
                end else begin
                    r_rem[g+1]  <= r_rem[g];
                    r_root[g+1] <= r_root[g] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_root  = r_root[STEPS][ROOT_W-1:0];
    assign o_side  = r_side[STEPS];

endmodule

// File: design/ger_atan2.sv
// Vectoring-mode CORDIC pipeline: atan2(y, x) as a 48-bit phase.
module ger_atan2 #(
    parameter int STAGES = ger_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [ger_pkg::QW-1:0] i_y,
    input  logic signed [ger_pkg::QW-1:0] i_x,
    output logic                          o_valid,
    output logic [ger_pkg::PW-1:0]        o_z
);
    import ger_pkg::*;

    logic                 r_v    [0:STAGES];
    logic                 r_zero [0:STAGES];
    logic signed [QW-1:0] r_x    [0:STAGES];
    logic signed [QW-1:0] r_y    [0:STAGES];
    logic [PW-1:0]        r_z    [0:STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    // left half plane: mirror through the origin, start at half a turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x[QW-1]) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= PW'(1) << (PW - 1);
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        localparam logic [PW-1:0] ARC = f_arc(g);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (!r_y[g][QW-1]) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + ARC;
                end else begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - ARC;
                end
            end
        end
    end

    assign o_valid = r_v[STAGES];
    assign o_z     = r_zero[STAGES] ? '0 : r_z[STAGES];

endmodule

// File: design/galactic_equatorial_rotation_core.sv
// Top level: equatorial <-> galactic sky position rotation pipeline.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one position per transaction:
//   i_action (0 equatorial to galactic, 1 galactic to equatorial), i_in_lon
//   (unsigned binary angle) and i_in_lat (signed binary angle), 2^ANGLE_BITS
//   per turn. Output channel (o_valid / i_stall) returns one transaction per
//   input: o_out_lon wrapped to one turn and o_out_lat in +-1/4 turn.
//   Throughput: one transaction per clock while the output is not stalled.
//   The path from acceptance to o_valid runs through the two CORDIC chains
//   (sin/cos, then atan2) and the square-root pipeline between them.
//   Reset (synchronous, active low) clears every valid bit; nothing is in
//   flight afterwards. No clearing pass, the block accepts at once.
//   When the receiver stalls while a result is held, the whole pipeline
//   freezes and o_stall is raised; nothing is dropped or duplicated.
//   The advance enable is global: bubbles are not squeezed out while a result
//   waits, and every stage moves whenever the output register is empty or taken.
`include "galactic_equatorial_rotation_core_assert.svh"

module galactic_equatorial_rotation_core #(
    parameter int ANGLE_BITS    = ger_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = ger_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic [ANGLE_BITS-1:0]        i_in_lon,
    input  logic signed [ANGLE_BITS-1:0] i_in_lat,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ANGLE_BITS-1:0]        o_out_lon,
    output logic signed [ANGLE_BITS-1:0] o_out_lat
);
    import ger_pkg::*;

    localparam int SH = PW - ANGLE_BITS;
    localparam logic [PW-1:0] ROUND = (SH > 0) ? (PW'(1) << ((SH > 0) ? SH - 1 : 0)) : '0;
    localparam logic signed [PROD_W-1:0] ONE_P = PROD_W'(1) << FRAC_BITS;
    localparam logic signed [QW-1:0]     ONE_Q = QW'(1) << FRAC_BITS;
    localparam int SIDE_W = 1 + 3 * QW;

    // global advance: hold everything only while a result is blocked
    logic w_en;
    logic r_out_v;
    assign o_stall = r_out_v && i_stall;
    assign w_en    = !o_stall;
    assign o_valid = r_out_v;

    // stage 0: input register, longitude shifted by the first node
    logic          r0_v;
    logic          r0_d;
    logic [PW-1:0] r0_a;
    logic [PW-1:0] r0_lat;
    logic [PW-1:0] w_lon_ph;
    logic [PW-1:0] w_node_in;

    assign w_lon_ph  = PW'(i_in_lon) << SH;
    assign w_node_in = (i_action == ACT_GAL_TO_EQ) ? NODE_SMALL : NODE_LARGE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_d   <= i_action;
            r0_a   <= w_lon_ph - w_node_in;
            r0_lat <= PW'($unsigned(i_in_lat)) << SH;
        end
    end

    // sin/cos of shifted longitude and of latitude
    logic                 w_sc_v;
    logic signed [QW-1:0] w_ca, w_sa, w_cb, w_sb;
    logic                 r_d_sc [0:CORDIC_STAGES+1];

    ger_sincos #(.STAGES(CORDIC_STAGES)) u_sincos_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r0_v),
        .i_phase (r0_a),
        .o_valid (w_sc_v),
        .o_cos   (w_ca),
        .o_sin   (w_sa)
    );

    ger_sincos #(.STAGES(CORDIC_STAGES)) u_sincos_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r0_v),
        .i_phase (r0_lat),
        .o_valid (),
        .o_cos   (w_cb),
        .o_sin   (w_sb)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_sc[0] <= r0_d;
            for (int k = 0; k <= CORDIC_STAGES; k++) begin
                r_d_sc[k+1] <= r_d_sc[k];
            end
        end
    end

    // M1: cos(b)sin(a), cos(b)cos(a)
    logic                     r1_v, r1_d;
    logic signed [PROD_W-1:0] r1_cbsa_p, r1_xv_p;
    logic signed [QW-1:0]     r1_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_sc_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_d      <= r_d_sc[CORDIC_STAGES+1];
            r1_cbsa_p <= w_cb * w_sa;
            r1_xv_p   <= w_cb * w_ca;
            r1_sb     <= w_sb;
        end
    end

    // M2: tilt products
    logic                     r2_v, r2_d;
    logic signed [PROD_W-1:0] r2_p1, r2_p2, r2_p3, r2_p4;
    logic signed [QW-1:0]     r2_xv;
    logic signed [QW-1:0]     w_cbsa, w_ts, w_nts;

    assign w_cbsa = QW'(r1_cbsa_p >>> FRAC_BITS);
    assign w_ts   = (r1_d == ACT_GAL_TO_EQ) ? -TILT_S : TILT_S;
    assign w_nts  = -w_ts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_d  <= r1_d;
            r2_p1 <= w_nts * w_cbsa;
            r2_p2 <= TILT_C * r1_sb;
            r2_p3 <= TILT_C * w_cbsa;
            r2_p4 <= w_ts * r1_sb;
            r2_xv <= QW'(r1_xv_p >>> FRAC_BITS);
        end
    end

    // M3: new-latitude sine (clamped to +-1) and atan2 numerator
    logic                     r3_v, r3_d;
    logic signed [QW-1:0]     r3_sv, r3_yv, r3_xv;
    logic signed [PROD_W-1:0] w_s_sh;
    logic signed [PROD_W-1:0] w_y_sh;

    assign w_s_sh = (r2_p1 + r2_p2) >>> FRAC_BITS;
    assign w_y_sh = (r2_p3 + r2_p4) >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_d <= r2_d;
            if (w_s_sh > ONE_P) begin
                r3_sv <= ONE_Q;
            end else if (w_s_sh < -ONE_P) begin
                r3_sv <= -ONE_Q;
            end else begin
                r3_sv <= QW'(w_s_sh);
            end
            r3_yv <= QW'(w_y_sh);
            r3_xv <= r2_xv;
        end
    end

    // M4: sine squared
    logic                     r4_v, r4_d;
    logic [RAD_W-1:0]         r4_sq;
    logic signed [QW-1:0]     r4_sv, r4_yv, r4_xv;
    logic signed [PROD_W-1:0] w_sq_full;

    assign w_sq_full = r3_sv * r3_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (w_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_d  <= r3_d;
            r4_sq <= w_sq_full[RAD_W-1:0];
            r4_sv <= r3_sv;
            r4_yv <= r3_yv;
            r4_xv <= r3_xv;
        end
    end

    // cosine of the new latitude: sqrt(1 - s^2)
    logic [RAD_W-1:0]     w_rad;
    logic                 w_is_v;
    logic [ROOT_W-1:0]    w_root;
    logic [SIDE_W-1:0]    w_is_side;
    logic                 w_is_d;
    logic signed [QW-1:0] w_is_sv, w_is_yv, w_is_xv;

    assign w_rad = (RAD_W'(1) << (2 * FRAC_BITS)) - r4_sq;

    ger_isqrt #(.SIDE_W(SIDE_W)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_v),
        .i_rad   (w_rad),
        .i_side  ({r4_d, r4_sv, r4_yv, r4_xv}),
        .o_valid (w_is_v),
        .o_root  (w_root),
        .o_side  (w_is_side)
    );

    assign {w_is_d, w_is_sv, w_is_yv, w_is_xv} = w_is_side;

    // both arctangents in parallel
    logic          w_at_v;
    logic [PW-1:0] w_lat_z, w_lon_z;
    logic          r_d_at [0:CORDIC_STAGES];

    ger_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_lat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_is_v),
        .i_y     (w_is_sv),
        .i_x     ($signed(QW'(w_root))),
        .o_valid (w_at_v),
        .o_z     (w_lat_z)
    );

    ger_atan2 #(.STAGES(CORDIC_STAGES)) u_atan_lon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_is_v),
        .i_y     (w_is_yv),
        .i_x     (w_is_xv),
        .o_valid (),
        .o_z     (w_lon_z)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_at[0] <= w_is_d;
            for (int k = 0; k < CORDIC_STAGES; k++) begin
                r_d_at[k+1] <= r_d_at[k];
            end
        end
    end

    // output: add second node, round half up to ANGLE_BITS
    logic [PW-1:0] w_node_out, w_lon_rnd, w_lat_rnd;

    assign w_node_out = (r_d_at[CORDIC_STAGES] == ACT_GAL_TO_EQ) ? NODE_LARGE : NODE_SMALL;
    assign w_lon_rnd  = w_lon_z + w_node_out + ROUND;
    assign w_lat_rnd  = w_lat_z + ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_at_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_out_lon <= w_lon_rnd[PW-1 -: ANGLE_BITS];
            o_out_lat <= $signed(w_lat_rnd[PW-1 -: ANGLE_BITS]);
        end
    end

    `GER_ASSERT_NOW(a_sine_clamped, i_clk, i_rst_n, r3_v, (r3_sv <= ONE_Q) && (r3_sv >= -ONE_Q))
    `GER_ASSERT_NOW(a_stall_only_on_result, i_clk, i_rst_n, o_stall, o_valid)
    `GER_ASSERT_NEXT(a_frozen_on_stall, i_clk, i_rst_n, o_stall, $stable(r1_v) && $stable(r4_v))

endmodule
